// ===== rtl/pmaw_pkg.sv =====
// Shared widths, payload types and constants for the pose moving average block.
// No dependencies; compiled first.
`default_nettype none

package pmaw_pkg;

   localparam int POS_W          = 24;
   localparam int HDG_W          = 16;
   localparam int WLEN_W         = 5;
   localparam int WINDOW_MAX_DEF = 16;
   localparam int LANES          = 3;

   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_H = 2;

   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic signed [HDG_W-1:0] hdg_type;
   typedef logic [WLEN_W-1:0]       wlen_type;

   localparam wlen_type WLEN_RESET = wlen_type'(5);

endpackage

`default_nettype wire

// ===== rtl/pmaw_ifs.sv =====
// Valid/ready channel interfaces for the request, response and CSR write ports.
// Depends on pmaw_pkg for the payload types.
`default_nettype none

interface pmaw_req_if import pmaw_pkg::*; ();
   logic    valid;
   logic    ready;
   pos_type pos_x;
   pos_type pos_y;
   hdg_type heading;
   logic    first_point;

   modport source (output valid, output pos_x, output pos_y, output heading,
                   output first_point, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input heading,
                   input first_point, output ready);
endinterface

interface pmaw_rsp_if import pmaw_pkg::*; ();
   logic    valid;
   logic    ready;
   pos_type avg_x;
   pos_type avg_y;
   hdg_type avg_heading;

   modport source (output valid, output avg_x, output avg_y, output avg_heading,
                   input ready);
   modport sink   (input valid, input avg_x, input avg_y, input avg_heading,
                   output ready);
endinterface

interface pmaw_csr_if import pmaw_pkg::*; ();
   logic     valid;
   logic     ready;
   wlen_type window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/pmaw_div.sv =====
// Three-lane restoring divider, one quotient bit per cycle, signed dividend
// truncated toward zero. Depends on pmaw_pkg for the lane count.
`default_nettype none

module pmaw_div import pmaw_pkg::*; #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DEN_W-1:0]        den,
   input  logic signed [NUM_W-1:0] num [LANES],
   output logic                    done,
   output logic signed [NUM_W-1:0] quo [LANES]
);

   localparam int ITER_W = $clog2(NUM_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  rem_ff  [LANES];
   logic [NUM_W-1:0]  quo_ff  [LANES];
   logic              neg_ff  [LANES];

   logic [DEN_W:0]    trial   [LANES];
   logic [DEN_W:0]    diff    [LANES];
   logic              ge      [LANES];
   logic [DEN_W-1:0]  rem_in  [LANES];
   logic [NUM_W-1:0]  quo_in  [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         trial[i]  = {rem_ff[i], quo_ff[i][NUM_W-1]};
         diff[i]   = trial[i] - {1'b0, den_ff};
         ge[i]     = trial[i] >= {1'b0, den_ff};
         rem_in[i] = ge[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
         quo_in[i] = {quo_ff[i][NUM_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= ITER_W'(NUM_W);
         end else if (busy_ff) begin
            iter_ff <= iter_ff - 1'b1;
            if (iter_ff == ITER_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         for (int i = 0; i < LANES; i++) begin
            rem_ff[i] <= '0;
            neg_ff[i] <= num[i][NUM_W-1];
            quo_ff[i] <= num[i][NUM_W-1] ? (~num[i] + 1'b1) : num[i];
         end
      end else if (busy_ff) begin
         for (int i = 0; i < LANES; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         quo[i] = neg_ff[i] ? (~quo_ff[i] + 1'b1) : quo_ff[i];
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/pose_moving_average_warmup.sv =====
// Each request reads count window entries and divides their sums, count =
// min(points in list, window), NUM_W = 24 + log2(WINDOW_MAX) dividend bits.
// One request at a time: a new one is taken only after the previous response is loaded;
// the window memory read port (one entry per cycle) and the bit-serial divider set the pace.
// Reset: synchronous, active high; clears fill count and write slot, window length to 5.
// The window memory is not cleared; only entries of the current list are read.
`default_nettype none

module pose_moving_average_warmup import pmaw_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pmaw_req_if.sink   req_if,
   pmaw_rsp_if.source rsp_if,
   pmaw_csr_if.sink   csr_if
);

   localparam int SLOT_W  = $clog2(WINDOW_MAX);
   localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
   localparam int LEN_W   = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
   localparam int SUM_W   = POS_W + $clog2(WINDOW_MAX);
   localparam int SUMH_W  = HDG_W + $clog2(WINDOW_MAX);
   localparam int ENTRY_W = 2 * POS_W + HDG_W;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_MAX - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW_MAX);
   localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(WINDOW_MAX);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [ENTRY_W-1:0]      mem [WINDOW_MAX];

   logic [1:0]              state_ff, state_in;
   wlen_type                wlen_ff;
   logic [SLOT_W-1:0]       write_slot_ff, write_slot_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [SLOT_W-1:0]       rd_slot_ff, rd_slot_in;
   logic [CNT_W-1:0]        issue_left_ff, issue_left_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rd_vld_ff;
   logic [ENTRY_W-1:0]      rd_data_ff;
   logic signed [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0] sum_y_ff, sum_y_in;
   logic signed [SUMH_W-1:0] sum_h_ff, sum_h_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pos_type                 avg_x_ff, avg_y_ff;
   hdg_type                 avg_h_ff;

   logic                    req_fire;
   logic                    rd_en;
   logic                    div_start;
   logic                    div_done;
   logic                    rsp_load;
   logic [SLOT_W-1:0]       wr_slot;
   logic [CNT_W-1:0]        fill_base;
   logic [LEN_W-1:0]        wl_ext;
   logic [LEN_W-1:0]        len_w;
   logic [CNT_W-1:0]        len;
   logic signed [SUM_W-1:0] div_num [LANES];
   logic signed [SUM_W-1:0] div_quo [LANES];
   pos_type                 rd_x, rd_y;
   hdg_type                 rd_h;

   assign req_fire = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;

   assign wl_ext = LEN_W'(wlen_ff);
   assign len_w  = (wl_ext == '0) ? LEN_W'(1) : ((wl_ext > LEN_MAX) ? LEN_MAX : wl_ext);
   assign len    = len_w[CNT_W-1:0];

   assign wr_slot   = req_if.first_point ? '0 : write_slot_ff;
   assign fill_base = req_if.first_point ? '0 : fill_ff;

   assign rd_en     = (state_ff == ST_READ) && (issue_left_ff != '0);
   assign div_start = (state_ff == ST_READ) && (issue_left_ff == '0) && !rd_vld_ff;
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_if.ready);

   assign rd_x = rd_data_ff[POS_W-1:0];
   assign rd_y = rd_data_ff[2*POS_W-1:POS_W];
   assign rd_h = rd_data_ff[ENTRY_W-1:2*POS_W];

   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      fill_in       = fill_ff;
      rd_slot_in    = rd_slot_ff;
      issue_left_in = issue_left_ff;
      count_in      = count_ff;
      sum_x_in      = sum_x_ff;
      sum_y_in      = sum_y_ff;
      sum_h_in      = sum_h_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;

      if (rd_vld_ff) begin
         sum_x_in = sum_x_ff + {{(SUM_W-POS_W){rd_x[POS_W-1]}}, rd_x};
         sum_y_in = sum_y_ff + {{(SUM_W-POS_W){rd_y[POS_W-1]}}, rd_y};
         sum_h_in = sum_h_ff + {{(SUMH_W-HDG_W){rd_h[HDG_W-1]}}, rd_h};
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               write_slot_in = (wr_slot == SLOT_LAST) ? '0 : wr_slot + 1'b1;
               fill_in       = (fill_base == CNT_FULL) ? fill_base : fill_base + 1'b1;
               count_in      = (fill_in < len) ? fill_in : len;
               issue_left_in = count_in;
               rd_slot_in    = wr_slot;
               sum_x_in      = '0;
               sum_y_in      = '0;
               sum_h_in      = '0;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            if (rd_en) begin
               issue_left_in = issue_left_ff - 1'b1;
               rd_slot_in    = (rd_slot_ff == '0) ? SLOT_LAST : rd_slot_ff - 1'b1;
            end
            if (div_start) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wlen_ff       <= WLEN_RESET;
         write_slot_ff <= '0;
         fill_ff       <= '0;
         issue_left_ff <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         fill_ff       <= fill_in;
         issue_left_ff <= issue_left_in;
         rd_vld_ff     <= rd_en;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            wlen_ff <= csr_if.window_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= rd_slot_in;
      count_ff   <= count_in;
      sum_x_ff   <= sum_x_in;
      sum_y_ff   <= sum_y_in;
      sum_h_ff   <= sum_h_in;
      if (rsp_load) begin
         avg_x_ff <= div_quo[LANE_X][POS_W-1:0];
         avg_y_ff <= div_quo[LANE_Y][POS_W-1:0];
         avg_h_ff <= div_quo[LANE_H][HDG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mem[wr_slot] <= {req_if.heading, req_if.pos_y, req_if.pos_x};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_slot_ff];
      end
   end

   assign div_num[LANE_X] = sum_x_ff;
   assign div_num[LANE_Y] = sum_y_ff;
   assign div_num[LANE_H] = {{(SUM_W-SUMH_W){sum_h_ff[SUMH_W-1]}}, sum_h_ff};

   pmaw_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .den   (count_ff),
      .num   (div_num),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.avg_x       = avg_x_ff;
   assign rsp_if.avg_y       = avg_y_ff;
   assign rsp_if.avg_heading = avg_h_ff;

endmodule

`default_nettype wire

// ===== rtl/pmaw_checker.sv =====
// Port-level assertions for pose_moving_average_warmup, attached by bind.
// Depends on pmaw_pkg and the top level's channel interfaces.
`default_nettype none

module pmaw_port_checks import pmaw_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input pos_type rsp_avg_x,
   input pos_type rsp_avg_y,
   input hdg_type rsp_avg_heading
);

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_avg_x) && $stable(rsp_avg_y)
         && $stable(rsp_avg_heading))
      else $error("response dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while previous request in flight");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && !rsp_valid |=> !rsp_valid)
      else $error("response appeared one cycle after request");

endmodule

bind pose_moving_average_warmup pmaw_port_checks u_pmaw_port_checks (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_avg_x       (rsp_if.avg_x),
   .rsp_avg_y       (rsp_if.avg_y),
   .rsp_avg_heading (rsp_if.avg_heading)
);

`default_nettype wire

// ===== test/pmaw_checker.sv =====
// Checker for the pose moving average block: watches the request, response and CSR
// channels, predicts each windowed mean and compares it field by field.
// Depends on pmaw_pkg and the channel interfaces in pmaw_ifs.
module pmaw_checker import pmaw_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic clock,
   input  logic reset,
   pmaw_req_if  req_if,
   pmaw_rsp_if  rsp_if,
   pmaw_csr_if  csr_if,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      pos_type x;
      pos_type y;
      hdg_type h;
   } pose_mean_type;

   pos_type       ring_x [WINDOW_MAX];
   pos_type       ring_y [WINDOW_MAX];
   hdg_type       ring_h [WINDOW_MAX];
   int unsigned   points_held;
   int unsigned   next_slot;
   wlen_type      cfg_len;
   pose_mean_type pending_means [$];
   int            mismatches = 0;

   function automatic pose_mean_type window_mean(pos_type px, pos_type py, hdg_type ph,
                                                 logic fp);
      longint        acc_x;
      longint        acc_y;
      longint        acc_h;
      int unsigned   span;
      int unsigned   n;
      int unsigned   idx;
      pose_mean_type m;
      if (fp) begin
         points_held = 0;
         next_slot   = 0;
      end
      ring_x[next_slot] = px;
      ring_y[next_slot] = py;
      ring_h[next_slot] = ph;
      next_slot = (next_slot + 1 == WINDOW_MAX) ? 0 : next_slot + 1;
      if (points_held < WINDOW_MAX) points_held++;
      if (cfg_len == 0) span = 1;
      else if (cfg_len > WINDOW_MAX) span = WINDOW_MAX;
      else span = cfg_len;
      n     = (points_held < span) ? points_held : span;
      acc_x = 0;
      acc_y = 0;
      acc_h = 0;
      idx   = next_slot;
      for (int unsigned k = 0; k < n; k++) begin
         idx = (idx == 0) ? WINDOW_MAX - 1 : idx - 1;
         acc_x += ring_x[idx];
         acc_y += ring_y[idx];
         acc_h += ring_h[idx];
      end
      m.x = pos_type'(acc_x / longint'(n));
      m.y = pos_type'(acc_y / longint'(n));
      m.h = hdg_type'(acc_h / longint'(n));
      return m;
   endfunction

   always @(posedge clock) begin
      pose_mean_type want;
      if (reset) begin
         points_held = 0;
         next_slot   = 0;
         cfg_len     = WLEN_RESET;
         pending_means.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_means.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: x=%0d y=%0d heading=%0d",
                           rsp_if.avg_x, rsp_if.avg_y, rsp_if.avg_heading);
            end else begin
               want = pending_means.pop_front();
               if (rsp_if.avg_x !== want.x || rsp_if.avg_y !== want.y ||
                   rsp_if.avg_heading !== want.h) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp x=%0d y=%0d h=%0d, got x=%0d y=%0d h=%0d",
                              want.x, want.y, want.h,
                              rsp_if.avg_x, rsp_if.avg_y, rsp_if.avg_heading);
               end
            end
         end
         if (csr_if.valid && csr_if.ready) cfg_len = csr_if.window_length;
         if (req_if.valid && req_if.ready)
            pending_means.push_back(window_mean(req_if.pos_x, req_if.pos_y,
                                                req_if.heading, req_if.first_point));
      end
      fail_count <= mismatches;
      pending    <= pending_means.size();
   end

endmodule

// ===== test/tb.sv =====
// Testbench top for pose_moving_average_warmup: drives requests and window-length
// writes under varying back-pressure and gives the verdict from pmaw_checker.
// Depends on pmaw_pkg, pmaw_ifs, the block and pmaw_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pmaw_pkg::*;

   localparam int      CYCLE_LIMIT   = 1_000_000;
   localparam int      HOLD_CYCLES   = 600;
   localparam int      SETTLE_CYCLES = 64;
   localparam pos_type POS_MAX       = 24'sh7FFFFF;
   localparam pos_type POS_MIN       = 24'sh800000;
   localparam hdg_type HDG_MAX       = 16'sh7FFF;
   localparam hdg_type HDG_MIN       = 16'sh8000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        rsp_hold = 1'b0;
   bit          hold_go = 1'b0;
   int unsigned send_idle_pct = 17;
   int unsigned rsp_stall_pct = 79;
   int unsigned points_sent = 0;
   int unsigned cycle_count = 0;
   int          fail_count;
   int          pending;

   pmaw_req_if req_if ();
   pmaw_rsp_if rsp_if ();
   pmaw_csr_if csr_if ();

   pose_moving_average_warmup u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   pmaw_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_if     (csr_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // hold off the response side long enough for the block to stall its input
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic pos_type rand_pos();
      case ($urandom_range(7))
         0: return POS_MAX;
         1: return POS_MIN;
         default: return pos_type'($urandom());
      endcase
   endfunction

   function automatic hdg_type rand_hdg();
      case ($urandom_range(7))
         0: return HDG_MAX;
         1: return HDG_MIN;
         default: return hdg_type'($urandom());
      endcase
   endfunction

   task automatic set_pace(int unsigned idle_pct, int unsigned stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
   endtask

   task automatic send_point(pos_type px, pos_type py, hdg_type ph, logic fp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.pos_x       <= px;
      req_if.pos_y       <= py;
      req_if.heading     <= ph;
      req_if.first_point <= fp;
      do @(posedge clock); while (!req_if.ready);
      points_sent++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_window(wlen_type len);
      drain_results();
      csr_if.valid         <= 1'b1;
      csr_if.window_length <= len;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_list(int unsigned len);
      bit      steady;
      pos_type cx;
      pos_type cy;
      hdg_type ch;
      steady = ($urandom_range(9) == 0);
      cx = $urandom_range(1) ? POS_MAX : POS_MIN;
      cy = $urandom_range(1) ? POS_MAX : POS_MIN;
      ch = $urandom_range(1) ? HDG_MAX : HDG_MIN;
      for (int unsigned k = 0; k < len; k++) begin
         if (steady) send_point(cx, cy, ch, k == 0);
         else send_point(rand_pos(), rand_pos(), rand_hdg(),
                         k == 0 || $urandom_range(99) < 3);
      end
   endtask

   task automatic run_lists(int unsigned count);
      int unsigned stop_at;
      stop_at = points_sent + count;
      while (points_sent < stop_at) begin
         if ($urandom_range(5) == 0) begin
            if ($urandom_range(9) == 0) write_window(wlen_type'($urandom_range(17, 31)));
            else write_window(wlen_type'($urandom_range(0, 16)));
         end
         send_list($urandom_range(1, 40));
      end
   endtask

   initial begin
      req_if.valid         = 1'b0;
      req_if.pos_x         = '0;
      req_if.pos_y         = '0;
      req_if.heading       = '0;
      req_if.first_point   = 1'b0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.window_length = WLEN_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // stream starts without a first point, reset window of five
      send_point(POS_MAX, POS_MIN, HDG_MAX, 1'b0);
      send_point(POS_MAX, POS_MIN, HDG_MAX, 1'b0);
      send_point(POS_MIN, POS_MAX, HDG_MIN, 1'b1);
      repeat (4) send_point(POS_MIN, POS_MAX, HDG_MIN, 1'b0);
      // truncation toward zero on both signs
      send_point(pos_type'(1), pos_type'(-1), hdg_type'(1), 1'b1);
      send_point(pos_type'(0), pos_type'(0), hdg_type'(0), 1'b0);
      send_point(pos_type'(-2), pos_type'(2), hdg_type'(-1), 1'b0);
      // back-to-back single-point lists
      send_point(24'sh555555, 24'shAAAAAA, 16'sh5555, 1'b1);
      send_point(pos_type'(-5), pos_type'(7), hdg_type'(3), 1'b1);
      // window changes mid-list, including zero and oversize lengths
      write_window(wlen_type'(2));
      send_point(pos_type'(100), pos_type'(-300), hdg_type'(50), 1'b0);
      send_point(pos_type'(-101), pos_type'(301), hdg_type'(-51), 1'b0);
      write_window(wlen_type'(0));
      send_point(POS_MAX, POS_MAX, HDG_MAX, 1'b0);
      send_point(POS_MIN, POS_MIN, HDG_MIN, 1'b0);
      write_window(wlen_type'(31));
      repeat (3) send_point(rand_pos(), rand_pos(), rand_hdg(), 1'b0);
      write_window(wlen_type'(17));
      send_point(pos_type'(9), pos_type'(-9), hdg_type'(9), 1'b0);

      write_window(wlen_type'(1));
      run_lists(560);

      drain_results();
      set_pace(79, 17);
      write_window(wlen_type'(16));
      run_lists(560);

      drain_results();
      set_pace(0, 0);
      write_window(wlen_type'(1));
      hold_go = 1'b1;
      send_list(12);
      run_lists(548);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
